// File: rtl/msv_pkg.sv
`default_nettype none
package msv_pkg;

  localparam int MAX_NEST_DEFAULT = 3;

  localparam logic [9:0]  MAX_LINK_LEN_RESET = 10'd256;
  localparam logic [10:0] TARGET_LEN_MAX     = 11'd2047;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] PFX_HTTPS_LEN = 4'd8;
  localparam logic [3:0] PFX_HTTP_LEN  = 4'd7;

  localparam logic [7:0] CH_LT        = 8'h3c;
  localparam logic [7:0] CH_GT        = 8'h3e;
  localparam logic [7:0] CH_BOLD      = 8'h02;
  localparam logic [7:0] CH_COLOUR    = 8'h03;
  localparam logic [7:0] CH_PLAIN     = 8'h0f;
  localparam logic [7:0] CH_REVERSE   = 8'h16;
  localparam logic [7:0] CH_ITALIC    = 8'h1d;
  localparam logic [7:0] CH_UNDERLINE = 8'h1f;
  localparam logic [7:0] CH_STRIKE    = 8'h1e;
  localparam logic [7:0] CH_MONO      = 8'h11;
  localparam logic [7:0] CH_STAR      = 8'h2a;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_TILDE     = 8'h7e;
  localparam logic [7:0] CH_BACKTICK  = 8'h60;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_RBRACKET  = 8'h5d;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_FORBIDDEN = 2'd1,
    VERDICT_DEPTH     = 2'd2,
    VERDICT_LINK      = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    MARK_STAR  = 2'd0,
    MARK_UNDER = 2'd1,
    MARK_TILDE = 2'd2,
    MARK_TICK  = 2'd3
  } marker_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       forbidden;
    logic       is_marker;
    marker_t    code;
    logic       backslash;
    logic       lparen;
    logic       rparen;
  } entry_t;

  function automatic logic [7:0] https_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h68;
      4'd1:    c = 8'h74;
      4'd2:    c = 8'h74;
      4'd3:    c = 8'h70;
      4'd4:    c = 8'h73;
      4'd5:    c = 8'h3a;
      4'd6:    c = 8'h2f;
      4'd7:    c = 8'h2f;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] http_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h68;
      4'd1:    c = 8'h74;
      4'd2:    c = 8'h74;
      4'd3:    c = 8'h70;
      4'd4:    c = 8'h3a;
      4'd5:    c = 8'h2f;
      4'd6:    c = 8'h2f;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/msv_if.sv
`default_nettype none
interface msv_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface msv_verdict_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface
`default_nettype wire

// File: rtl/msv_front.sv
`default_nettype none
module msv_front (
  msv_text_if.sink        text,
  input  wire logic       full,
  output msv_pkg::entry_t entry,
  output logic            push
);

  assign text.ready = !full;
  assign push       = text.valid && !full;

  always_comb begin
    entry           = '0;
    entry.data      = text.text_byte;
    entry.last      = text.last_byte;
    entry.forbidden = text.text_byte inside {
      msv_pkg::CH_LT, msv_pkg::CH_GT, msv_pkg::CH_BOLD, msv_pkg::CH_COLOUR,
      msv_pkg::CH_PLAIN, msv_pkg::CH_REVERSE, msv_pkg::CH_ITALIC,
      msv_pkg::CH_UNDERLINE, msv_pkg::CH_STRIKE, msv_pkg::CH_MONO};
    entry.backslash = (text.text_byte == msv_pkg::CH_BACKSLASH);
    entry.lparen    = (text.text_byte == msv_pkg::CH_LPAREN);
    entry.rparen    = (text.text_byte == msv_pkg::CH_RPAREN);
    entry.is_marker = 1'b1;
    entry.code      = msv_pkg::MARK_STAR;
    case (text.text_byte)
      msv_pkg::CH_STAR:       entry.code = msv_pkg::MARK_STAR;
      msv_pkg::CH_UNDERSCORE: entry.code = msv_pkg::MARK_UNDER;
      msv_pkg::CH_TILDE:      entry.code = msv_pkg::MARK_TILDE;
      msv_pkg::CH_BACKTICK:   entry.code = msv_pkg::MARK_TICK;
      default:                entry.is_marker = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/msv_queue.sv
`default_nettype none
module msv_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire msv_pkg::entry_t push_entry,
  input  wire logic            pop,
  output msv_pkg::entry_t      head,
  output logic                 full,
  output logic                 empty
);

  localparam logic [msv_pkg::QUEUE_AW:0] DEPTH = (msv_pkg::QUEUE_AW + 1)'(msv_pkg::QUEUE_DEPTH);

  msv_pkg::entry_t               mem [msv_pkg::QUEUE_DEPTH];
  logic [msv_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [msv_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [msv_pkg::QUEUE_AW:0]    count;

  assign full  = (count == DEPTH);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("request pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("request popped from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH)
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// File: rtl/msv_back.sv
`default_nettype none
module msv_back #(
  parameter int MAX_NEST = msv_pkg::MAX_NEST_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [9:0]      cfg_wdata,
  input  wire msv_pkg::entry_t head,
  input  wire logic            empty,
  output logic                 pop,
  msv_verdict_if.source        result
);

  localparam int NEST_W = $clog2(MAX_NEST + 1);
  localparam int IDX_W  = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
  localparam logic [NEST_W-1:0] NEST_FULL = NEST_W'(MAX_NEST);

  logic [9:0]        max_link_len;
  logic [7:0]        previous_byte, previous_byte_next;
  logic              escape_pending, escape_pending_next;
  logic              previous_was_marker, previous_was_marker_next;
  msv_pkg::marker_t  marker_stack [MAX_NEST];
  logic [NEST_W-1:0] nest_count, nest_count_next;
  logic              inside_target, inside_target_next;
  logic [10:0]       target_length, target_length_next;
  logic [3:0]        prefix_position, prefix_position_next;
  logic              http_matching, http_matching_next;
  logic              https_matching, https_matching_next;
  logic              forbidden_seen, forbidden_seen_next;
  logic              depth_failed, depth_failed_next;
  logic              link_failed, link_failed_next;
  logic              out_valid, out_valid_next;
  msv_pkg::verdict_t verdict, verdict_next;
  logic              stack_we;
  logic [IDX_W-1:0]  stack_widx;
  logic [IDX_W-1:0]  top_idx;
  logic [7:0]        lc;

  function automatic logic target_bad(input logic [10:0] len, input logic [3:0] pos,
                                      input logic hm, input logic hsm,
                                      input logic [9:0] limit);
    logic ok_prefix;
    ok_prefix = ((pos >= msv_pkg::PFX_HTTPS_LEN) && hsm) ||
                ((pos >= msv_pkg::PFX_HTTP_LEN) && hm);
    return (len > {1'b0, limit}) || !ok_prefix;
  endfunction

  assign top_idx      = IDX_W'(nest_count - 1'b1);
  assign stack_widx   = IDX_W'(nest_count);
  assign result.valid   = out_valid;
  assign result.verdict = verdict;

  always_comb begin
    pop = !empty && (!head.last || !out_valid || result.ready);
    previous_byte_next       = previous_byte;
    escape_pending_next      = escape_pending;
    previous_was_marker_next = previous_was_marker;
    nest_count_next          = nest_count;
    inside_target_next       = inside_target;
    target_length_next       = target_length;
    prefix_position_next     = prefix_position;
    http_matching_next       = http_matching;
    https_matching_next      = https_matching;
    forbidden_seen_next      = forbidden_seen;
    depth_failed_next        = depth_failed;
    link_failed_next         = link_failed;
    out_valid_next           = out_valid && !result.ready;
    verdict_next             = verdict;
    stack_we                 = 1'b0;
    lc = (head.data inside {[msv_pkg::CH_UPPER_A:msv_pkg::CH_UPPER_Z]}) ?
         head.data + msv_pkg::CASE_OFFSET : head.data;

    if (pop) begin
      if (head.forbidden) begin
        forbidden_seen_next = 1'b1;
      end

      // nesting of emphasis markers
      if (escape_pending) begin
        escape_pending_next      = 1'b0;
        previous_was_marker_next = 1'b0;
      end else if (head.backslash) begin
        escape_pending_next      = !head.last;
        previous_was_marker_next = 1'b0;
      end else if (!head.is_marker) begin
        previous_was_marker_next = 1'b0;
      end else if (!(previous_was_marker && previous_byte == head.data)) begin
        previous_was_marker_next = 1'b1;
        if (nest_count != '0 && marker_stack[top_idx] == head.code) begin
          nest_count_next = nest_count - 1'b1;
        end else if (nest_count >= NEST_FULL) begin
          depth_failed_next = 1'b1;
        end else begin
          stack_we        = 1'b1;
          nest_count_next = nest_count + 1'b1;
        end
      end

      // link targets
      if (!inside_target) begin
        if (head.lparen && previous_byte == msv_pkg::CH_RBRACKET) begin
          inside_target_next   = 1'b1;
          target_length_next   = '0;
          prefix_position_next = '0;
          http_matching_next   = 1'b1;
          https_matching_next  = 1'b1;
        end
      end else if (head.rparen) begin
        inside_target_next = 1'b0;
        if (target_bad(target_length, prefix_position, http_matching, https_matching,
                       max_link_len)) begin
          link_failed_next = 1'b1;
        end
      end else begin
        if (target_length != msv_pkg::TARGET_LEN_MAX) begin
          target_length_next = target_length + 1'b1;
        end
        if (prefix_position < msv_pkg::PFX_HTTPS_LEN) begin
          if (lc != msv_pkg::https_char(prefix_position)) begin
            https_matching_next = 1'b0;
          end
          if (prefix_position < msv_pkg::PFX_HTTP_LEN &&
              lc != msv_pkg::http_char(prefix_position)) begin
            http_matching_next = 1'b0;
          end
          prefix_position_next = prefix_position + 1'b1;
        end
      end

      previous_byte_next = head.data;

      if (head.last) begin
        if (inside_target_next &&
            target_bad(target_length_next, prefix_position_next, http_matching_next,
                       https_matching_next, max_link_len)) begin
          link_failed_next = 1'b1;
        end
        if (forbidden_seen_next) begin
          verdict_next = msv_pkg::VERDICT_FORBIDDEN;
        end else if (depth_failed_next) begin
          verdict_next = msv_pkg::VERDICT_DEPTH;
        end else if (link_failed_next) begin
          verdict_next = msv_pkg::VERDICT_LINK;
        end else begin
          verdict_next = msv_pkg::VERDICT_OK;
        end
        out_valid_next           = 1'b1;
        previous_byte_next       = '0;
        escape_pending_next      = 1'b0;
        previous_was_marker_next = 1'b0;
        nest_count_next          = '0;
        inside_target_next       = 1'b0;
        target_length_next       = '0;
        prefix_position_next     = '0;
        http_matching_next       = 1'b1;
        https_matching_next      = 1'b1;
        forbidden_seen_next      = 1'b0;
        depth_failed_next        = 1'b0;
        link_failed_next         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      marker_stack[stack_widx] <= head.code;
    end
    verdict <= verdict_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_link_len        <= msv_pkg::MAX_LINK_LEN_RESET;
      previous_byte       <= '0;
      escape_pending      <= 1'b0;
      previous_was_marker <= 1'b0;
      nest_count          <= '0;
      inside_target       <= 1'b0;
      target_length       <= '0;
      prefix_position     <= '0;
      http_matching       <= 1'b1;
      https_matching      <= 1'b1;
      forbidden_seen      <= 1'b0;
      depth_failed        <= 1'b0;
      link_failed         <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_link_len <= cfg_wdata;
      end
      previous_byte       <= previous_byte_next;
      escape_pending      <= escape_pending_next;
      previous_was_marker <= previous_was_marker_next;
      nest_count          <= nest_count_next;
      inside_target       <= inside_target_next;
      target_length       <= target_length_next;
      prefix_position     <= prefix_position_next;
      http_matching       <= http_matching_next;
      https_matching      <= https_matching_next;
      forbidden_seen      <= forbidden_seen_next;
      depth_failed        <= depth_failed_next;
      link_failed         <= link_failed_next;
      out_valid           <= out_valid_next;
    end
  end

  a_nest_bound: assert property (@(posedge clk) disable iff (rst) nest_count <= NEST_FULL)
    else $error("nesting count beyond stack depth");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
      (pop && head.last) |=> (out_valid && nest_count == '0 && !inside_target &&
                              !escape_pending && !forbidden_seen))
    else $error("message state not cleared after verdict");

endmodule
`default_nettype wire

// File: rtl/markup_subset_validator_unit.sv
`default_nettype none
// channel   dir   payload                 handshake
// text      in    text_byte[8] last_byte  valid / ready
// result    out   verdict[2]              valid / ready
// cfg       in    cfg_wdata[10]           cfg_we, no wait
//
// one byte per cycle while the queue is not full; byte to queue in the accept
// cycle, back end updates state when it pops the byte, verdict shows in the
// cycle after the last byte leaves the queue
// rst (synchronous) clears all message state and sets max_link_len to 256
// a four-deep request queue keeps text flowing while a verdict waits; only
// the last byte of the next message waits behind an untaken verdict
module markup_subset_validator_unit #(
  parameter int MAX_NEST = msv_pkg::MAX_NEST_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [9:0] cfg_wdata,
  msv_text_if.sink        text,
  msv_verdict_if.source   result
);

  msv_pkg::entry_t push_entry;
  msv_pkg::entry_t head;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  msv_front u_front (
    .text  (text),
    .full  (full),
    .entry (push_entry),
    .push  (push)
  );

  msv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  msv_back #(
    .MAX_NEST (MAX_NEST)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
`default_nettype wire
